[design/fpim_pkg.sv]
// ----------------------------------------------------------------------------
// fpim_pkg
// Shared widths, codes and item types of the five-point interval minimizer.
// ----------------------------------------------------------------------------
package fpim_pkg;

  // Field widths
  localparam int unsigned POINT_WIDTH     = 32;
  localparam int unsigned VALUE_WIDTH     = 32;
  localparam int unsigned MAX_INNER_WIDTH = 8;

  // Configuration port
  localparam int unsigned                 ADDR_WIDTH      = 3;
  localparam int unsigned                 DATA_WIDTH      = 32;
  localparam logic [MAX_INNER_WIDTH-1:0]  MAX_INNER_RESET = 8'd20;
  localparam logic [ADDR_WIDTH-3:0]       REG_MAX_INNER   = 1'b0;

  // Input action codes
  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Probe slots, ordered from lower end to upper end
  localparam int unsigned NUM_SLOTS = 5;
  localparam int unsigned SLOT_LWR  = 0;
  localparam int unsigned SLOT_QTR  = 1;
  localparam int unsigned SLOT_MID  = 2;
  localparam int unsigned SLOT_3QT  = 3;
  localparam int unsigned SLOT_UPR  = 4;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_PROBE   = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_IGNORED = 2'd2
  } kind_e;

  typedef struct packed {
    logic                           action;
    logic signed [POINT_WIDTH-1:0]  lower_bound;
    logic signed [POINT_WIDTH-1:0]  upper_bound;
    logic signed [POINT_WIDTH-1:0]  start_point;
    logic signed [VALUE_WIDTH-1:0]  start_value;
    logic signed [VALUE_WIDTH-1:0]  sample_value;
  } in_item_t;

  typedef struct packed {
    kind_e                          kind;
    logic signed [POINT_WIDTH-1:0]  point;
    logic signed [VALUE_WIDTH-1:0]  value;
    logic                           improved;
  } out_item_t;

endpackage

[design/fpim_cfg.sv]
// ----------------------------------------------------------------------------
// fpim_cfg
// APB-style register file holding the inner iteration limit.
// ----------------------------------------------------------------------------
module fpim_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [fpim_pkg::ADDR_WIDTH-1:0]      paddr,
  input  logic [fpim_pkg::DATA_WIDTH-1:0]      pwdata,
  output logic [fpim_pkg::DATA_WIDTH-1:0]      prdata,
  output logic                                 pready,
  output logic [fpim_pkg::MAX_INNER_WIDTH-1:0] max_inner_o
);

  logic [fpim_pkg::MAX_INNER_WIDTH-1:0] max_inner_q;
  logic                                 sel_max_inner;

  // Decode the word address
  assign sel_max_inner = (paddr[fpim_pkg::ADDR_WIDTH-1:2] == fpim_pkg::REG_MAX_INNER);

  // Write the register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_inner_q <= fpim_pkg::MAX_INNER_RESET;
    end else if (psel && penable && pwrite && sel_max_inner) begin
      max_inner_q <= pwdata[fpim_pkg::MAX_INNER_WIDTH-1:0];
    end
  end

  // Read back, zero outside the map
  always_comb begin
    prdata = '0;
    if (sel_max_inner) begin
      prdata[fpim_pkg::MAX_INNER_WIDTH-1:0] = max_inner_q;
    end
  end

  assign pready      = 1'b1;
  assign max_inner_o = max_inner_q;

endmodule

[design/fpim_core.sv]
// ----------------------------------------------------------------------------
// fpim_core
// Search state and the combinational update that turns one item into a result.
// ----------------------------------------------------------------------------
module fpim_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  fpim_pkg::in_item_t                   item_i,
  input  logic [fpim_pkg::MAX_INNER_WIDTH-1:0] max_inner_i,
  output fpim_pkg::out_item_t                  result_o
);

  localparam int unsigned PW = fpim_pkg::POINT_WIDTH;
  localparam int unsigned VW = fpim_pkg::VALUE_WIDTH;
  localparam int unsigned CW = fpim_pkg::MAX_INNER_WIDTH;

  typedef enum logic [3:0] {
    PH_IDLE, PH_UPR0, PH_LWR0, PH_QTR0, PH_MID0, PH_3QT0, PH_NMID, PH_QTR, PH_3QT
  } phase_e;

  phase_e                phase_q, phase_d;
  logic signed [PW-1:0]  pts_q  [fpim_pkg::NUM_SLOTS];
  logic signed [PW-1:0]  pts_d  [fpim_pkg::NUM_SLOTS];
  logic signed [VW-1:0]  vals_q [fpim_pkg::NUM_SLOTS];
  logic signed [VW-1:0]  vals_d [fpim_pkg::NUM_SLOTS];
  logic signed [PW-1:0]  best_point_q, best_point_d;
  logic signed [VW-1:0]  best_value_q, best_value_d;
  logic signed [PW-1:0]  origin_point_q, origin_point_d;
  logic signed [VW-1:0]  origin_value_q, origin_value_d;
  logic [CW-1:0]         count_q, count_d;

  // Decision signals
  logic signed [VW-1:0]  vals_eff [fpim_pkg::NUM_SLOTS];
  logic signed [PW-1:0]  pts_cp   [fpim_pkg::NUM_SLOTS];
  logic signed [VW-1:0]  vals_cp  [fpim_pkg::NUM_SLOTS];
  logic [fpim_pkg::NUM_SLOTS-1:0] is_min;
  logic                  end_won;
  logic signed [PW-1:0]  win_point;
  logic signed [VW-1:0]  win_value;

  // Probe point unit
  logic signed [PW-1:0]  calc_lwr, calc_upr;
  logic signed [PW:0]    span, half, quart, three;
  logic [PW:0]           mid_sum, qtr_sum, tqt_sum;
  logic signed [PW-1:0]  c_mid, c_qtr, c_3qt;

  // Iteration limit
  logic [CW-1:0]         count_inc, limit;
  logic                  do_decide;

  // Substitute the arriving three-quarter sample into the value set
  always_comb begin
    for (int i = 0; i < fpim_pkg::NUM_SLOTS; i++) begin
      vals_eff[i] = vals_q[i];
    end
    vals_eff[fpim_pkg::SLOT_3QT] = item_i.sample_value;
  end

  // Flag each slot whose value is not above any other
  always_comb begin
    for (int k = 0; k < fpim_pkg::NUM_SLOTS; k++) begin
      is_min[k] = 1'b1;
      for (int i = 0; i < fpim_pkg::NUM_SLOTS; i++) begin
        if (vals_eff[k] > vals_eff[i]) begin
          is_min[k] = 1'b0;
        end
      end
    end
  end

  // Pick the winner by priority and narrow the interval around it
  always_comb begin
    for (int i = 0; i < fpim_pkg::NUM_SLOTS; i++) begin
      pts_cp[i]  = pts_q[i];
      vals_cp[i] = vals_eff[i];
    end
    end_won = 1'b0;
    if (is_min[fpim_pkg::SLOT_MID]) begin
      win_point = pts_q[fpim_pkg::SLOT_MID];
      win_value = vals_eff[fpim_pkg::SLOT_MID];
      pts_cp[fpim_pkg::SLOT_LWR]  = pts_q[fpim_pkg::SLOT_QTR];
      vals_cp[fpim_pkg::SLOT_LWR] = vals_eff[fpim_pkg::SLOT_QTR];
      pts_cp[fpim_pkg::SLOT_UPR]  = pts_q[fpim_pkg::SLOT_3QT];
      vals_cp[fpim_pkg::SLOT_UPR] = vals_eff[fpim_pkg::SLOT_3QT];
    end else if (is_min[fpim_pkg::SLOT_QTR]) begin
      win_point = pts_q[fpim_pkg::SLOT_QTR];
      win_value = vals_eff[fpim_pkg::SLOT_QTR];
      pts_cp[fpim_pkg::SLOT_UPR]  = pts_q[fpim_pkg::SLOT_MID];
      vals_cp[fpim_pkg::SLOT_UPR] = vals_eff[fpim_pkg::SLOT_MID];
      pts_cp[fpim_pkg::SLOT_MID]  = pts_q[fpim_pkg::SLOT_QTR];
      vals_cp[fpim_pkg::SLOT_MID] = vals_eff[fpim_pkg::SLOT_QTR];
    end else if (is_min[fpim_pkg::SLOT_3QT]) begin
      win_point = pts_q[fpim_pkg::SLOT_3QT];
      win_value = vals_eff[fpim_pkg::SLOT_3QT];
      pts_cp[fpim_pkg::SLOT_LWR]  = pts_q[fpim_pkg::SLOT_MID];
      vals_cp[fpim_pkg::SLOT_LWR] = vals_eff[fpim_pkg::SLOT_MID];
      pts_cp[fpim_pkg::SLOT_MID]  = pts_q[fpim_pkg::SLOT_3QT];
      vals_cp[fpim_pkg::SLOT_MID] = vals_eff[fpim_pkg::SLOT_3QT];
    end else if (is_min[fpim_pkg::SLOT_UPR]) begin
      win_point = pts_q[fpim_pkg::SLOT_UPR];
      win_value = vals_eff[fpim_pkg::SLOT_UPR];
      end_won   = 1'b1;
      pts_cp[fpim_pkg::SLOT_LWR]  = pts_q[fpim_pkg::SLOT_3QT];
      vals_cp[fpim_pkg::SLOT_LWR] = vals_eff[fpim_pkg::SLOT_3QT];
    end else begin
      win_point = pts_q[fpim_pkg::SLOT_LWR];
      win_value = vals_eff[fpim_pkg::SLOT_LWR];
      end_won   = 1'b1;
      pts_cp[fpim_pkg::SLOT_UPR]  = pts_q[fpim_pkg::SLOT_QTR];
      vals_cp[fpim_pkg::SLOT_UPR] = vals_eff[fpim_pkg::SLOT_QTR];
    end
  end

  // Select the interval ends that feed the probe point unit
  always_comb begin
    if (item_i.action == fpim_pkg::ACT_START) begin
      calc_lwr = item_i.lower_bound;
      calc_upr = item_i.upper_bound;
    end else if (phase_q == PH_NMID) begin
      calc_lwr = pts_q[fpim_pkg::SLOT_LWR];
      calc_upr = pts_q[fpim_pkg::SLOT_UPR];
    end else begin
      calc_lwr = pts_cp[fpim_pkg::SLOT_LWR];
      calc_upr = pts_cp[fpim_pkg::SLOT_UPR];
    end
  end

  // Span at one extra bit, fractions by arithmetic shift
  always_comb begin
    span    = {calc_upr[PW-1], calc_upr} - {calc_lwr[PW-1], calc_lwr};
    half    = span >>> 1;
    quart   = span >>> 2;
    three   = half + quart + {{PW{1'b0}}, &span[1:0]};
    mid_sum = {calc_lwr[PW-1], calc_lwr} + half;
    qtr_sum = {calc_lwr[PW-1], calc_lwr} + quart;
    tqt_sum = {calc_lwr[PW-1], calc_lwr} + three;
    c_mid   = mid_sum[PW-1:0];
    c_qtr   = qtr_sum[PW-1:0];
    c_3qt   = tqt_sum[PW-1:0];
  end

  assign count_inc = count_q + {{(CW-1){1'b0}}, 1'b1};
  assign limit     = (max_inner_i == '0) ? {{(CW-1){1'b0}}, 1'b1} : max_inner_i;

  // Next state and result for the accepted item
  always_comb begin
    phase_d        = phase_q;
    best_point_d   = best_point_q;
    best_value_d   = best_value_q;
    origin_point_d = origin_point_q;
    origin_value_d = origin_value_q;
    count_d        = count_q;
    do_decide      = 1'b0;
    for (int i = 0; i < fpim_pkg::NUM_SLOTS; i++) begin
      pts_d[i]  = pts_q[i];
      vals_d[i] = vals_q[i];
    end
    result_o          = '0;
    result_o.kind     = fpim_pkg::KIND_PROBE;

    if (item_i.action == fpim_pkg::ACT_START) begin
      // Load a fresh interval and ask for the upper end first
      pts_d[fpim_pkg::SLOT_LWR] = item_i.lower_bound;
      pts_d[fpim_pkg::SLOT_UPR] = item_i.upper_bound;
      pts_d[fpim_pkg::SLOT_QTR] = c_qtr;
      pts_d[fpim_pkg::SLOT_MID] = c_mid;
      pts_d[fpim_pkg::SLOT_3QT] = c_3qt;
      origin_point_d = item_i.start_point;
      origin_value_d = item_i.start_value;
      count_d        = '0;
      phase_d        = PH_UPR0;
      result_o.point = item_i.upper_bound;
    end else begin
      case (phase_q)
        PH_UPR0: begin
          vals_d[fpim_pkg::SLOT_UPR] = item_i.sample_value;
          phase_d        = PH_LWR0;
          result_o.point = pts_q[fpim_pkg::SLOT_LWR];
        end
        PH_LWR0: begin
          vals_d[fpim_pkg::SLOT_LWR] = item_i.sample_value;
          phase_d        = PH_QTR0;
          result_o.point = pts_q[fpim_pkg::SLOT_QTR];
        end
        PH_QTR0: begin
          vals_d[fpim_pkg::SLOT_QTR] = item_i.sample_value;
          phase_d        = PH_MID0;
          result_o.point = pts_q[fpim_pkg::SLOT_MID];
        end
        PH_MID0: begin
          vals_d[fpim_pkg::SLOT_MID] = item_i.sample_value;
          phase_d        = PH_3QT0;
          result_o.point = pts_q[fpim_pkg::SLOT_3QT];
        end
        PH_3QT0: begin
          do_decide = 1'b1;
        end
        PH_NMID: begin
          vals_d[fpim_pkg::SLOT_MID] = item_i.sample_value;
          pts_d[fpim_pkg::SLOT_QTR]  = c_qtr;
          pts_d[fpim_pkg::SLOT_3QT]  = c_3qt;
          phase_d        = PH_QTR;
          result_o.point = c_qtr;
        end
        PH_QTR: begin
          vals_d[fpim_pkg::SLOT_QTR] = item_i.sample_value;
          phase_d        = PH_3QT;
          result_o.point = pts_q[fpim_pkg::SLOT_3QT];
        end
        PH_3QT: begin
          count_d = count_inc;
          if (count_inc >= limit) begin
            // Report the best point, or revert to the origin
            vals_d[fpim_pkg::SLOT_3QT] = item_i.sample_value;
            phase_d       = PH_IDLE;
            result_o.kind = fpim_pkg::KIND_DONE;
            if (best_value_q < origin_value_q) begin
              result_o.point    = best_point_q;
              result_o.value    = best_value_q;
              result_o.improved = 1'b1;
            end else begin
              result_o.point = origin_point_q;
              result_o.value = origin_value_q;
            end
          end else begin
            do_decide = 1'b1;
          end
        end
        default: begin
          // Drop a sample that arrives with no search running
          phase_d       = PH_IDLE;
          result_o.kind = fpim_pkg::KIND_IGNORED;
        end
      endcase

      if (do_decide) begin
        best_point_d = win_point;
        best_value_d = win_value;
        for (int i = 0; i < fpim_pkg::NUM_SLOTS; i++) begin
          pts_d[i]  = pts_cp[i];
          vals_d[i] = vals_cp[i];
        end
        if (end_won) begin
          pts_d[fpim_pkg::SLOT_MID] = c_mid;
          phase_d        = PH_NMID;
          result_o.point = c_mid;
        end else begin
          pts_d[fpim_pkg::SLOT_QTR] = c_qtr;
          pts_d[fpim_pkg::SLOT_3QT] = c_3qt;
          phase_d        = PH_QTR;
          result_o.point = c_qtr;
        end
      end
    end
  end

  // Hold the search state, advance on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      best_point_q   <= '0;
      best_value_q   <= '0;
      origin_point_q <= '0;
      origin_value_q <= '0;
      count_q        <= '0;
      for (int i = 0; i < fpim_pkg::NUM_SLOTS; i++) begin
        pts_q[i]  <= '0;
        vals_q[i] <= '0;
      end
    end else if (accept_i) begin
      phase_q        <= phase_d;
      best_point_q   <= best_point_d;
      best_value_q   <= best_value_d;
      origin_point_q <= origin_point_d;
      origin_value_q <= origin_value_d;
      count_q        <= count_d;
      for (int i = 0; i < fpim_pkg::NUM_SLOTS; i++) begin
        pts_q[i]  <= pts_d[i];
        vals_q[i] <= vals_d[i];
      end
    end
  end

endmodule

[design/fpim_skid.sv]
// ----------------------------------------------------------------------------
// fpim_skid
// Output register with a skid stage; the input stall comes from a flop.
// ----------------------------------------------------------------------------
module fpim_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fpim_pkg::out_item_t item_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fpim_pkg::out_item_t out_item_o
);

  logic                out_valid_q, skid_valid_q;
  fpim_pkg::out_item_t out_q, skid_q;
  logic                out_free;

  // Output register can load when empty or being taken
  assign out_free = !out_valid_q || !out_stall_i;

  // Control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload: skid drains first, new item parks in skid while stalled
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : item_i;
    end else if (push_i) begin
      skid_q <= item_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[design/five_point_interval_minimizer_top.sv]
// ----------------------------------------------------------------------------
// five_point_interval_minimizer_top
// One-parameter five-point interval minimizer driven by an external evaluator.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  in       | input     | in_valid_i / in_stall_o  | in_item_i  (fpim_pkg::in_item_t)
//  out      | output    | out_valid_o / out_stall_i| out_item_o (fpim_pkg::out_item_t)
//  config   | input     | APB psel/penable/pready  | paddr, pwdata, prdata
//
//  Every item yields exactly one result; an item is taken every cycle while
//  the skid stage is empty.
//  The result is registered in the output register or the skid stage; the
//  search update is a five-way compare, a priority select, a 33-bit span
//  subtract and the probe-point adds between the state flops and those registers.
//  in_stall_o rises only once the output register and the skid stage both hold.
//  Reset leaves the search idle and max_inner at 20.
// ----------------------------------------------------------------------------
module five_point_interval_minimizer_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  fpim_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output fpim_pkg::out_item_t              out_item_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fpim_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [fpim_pkg::DATA_WIDTH-1:0]  pwdata,
  output logic [fpim_pkg::DATA_WIDTH-1:0]  prdata,
  output logic                             pready
);

  logic                                 accept;
  logic                                 skid_full;
  logic [fpim_pkg::MAX_INNER_WIDTH-1:0] max_inner;
  fpim_pkg::out_item_t                  result;

  // Take an item whenever the skid stage is free
  assign in_stall_o = skid_full;
  assign accept     = in_valid_i && !skid_full;

  fpim_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_inner_o (max_inner)
  );

  fpim_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .max_inner_i (max_inner),
    .result_o    (result)
  );

  fpim_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .item_i      (result),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

[design/fpim_checker.sv]
// ----------------------------------------------------------------------------
// fpim_checker
// Port-level checks of the minimizer, bound to the top level.
// ----------------------------------------------------------------------------
module fpim_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input fpim_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input fpim_pkg::out_item_t out_item_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // A start with a free output shows the upper-bound probe next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_item_i.action == fpim_pkg::ACT_START) &&
    (!out_valid_o || !out_stall_i)
    |=> out_valid_o && (out_item_o.kind == fpim_pkg::KIND_PROBE) &&
        (out_item_o.point == $past(in_item_i.upper_bound)))
    else $error("start did not request the upper bound");

  // Input stall only follows a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // Only a finished search may report an improvement
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.improved |-> out_item_o.kind == fpim_pkg::KIND_DONE)
    else $error("improved flag on a non-final result");

endmodule

bind five_point_interval_minimizer_top fpim_checker u_fpim_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
